### sv/skta_pkg.sv
`default_nettype none

package skta_pkg;

   // Table size and field widths.
   localparam int SESSIONS = 16;
   localparam int IDX_W    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
   localparam int SLOT_W   = 4;
   localparam int OP_W     = 3;
   localparam int CNT_W    = 32;
   localparam int SEC_W    = 16;
   localparam int ACT_W    = 2;
   localparam int CSR_IDX_W = 1;

   typedef logic [OP_W-1:0]  op_type;
   typedef logic [1:0]       slot_state_type;
   typedef logic [ACT_W-1:0] action_type;

   // Request opcodes.
   localparam op_type OP_TICK      = 3'd0;
   localparam op_type OP_OPEN      = 3'd1;
   localparam op_type OP_ESTABLISH = 3'd2;
   localparam op_type OP_SENT      = 3'd3;
   localparam op_type OP_RECEIVED  = 3'd4;
   localparam op_type OP_DATA      = 3'd5;
   localparam op_type OP_BUSY      = 3'd6;
   localparam op_type OP_CLOSE     = 3'd7;

   // Session life states.
   localparam slot_state_type SS_FREE        = 2'd0;
   localparam slot_state_type SS_NEGOTIATING = 2'd1;
   localparam slot_state_type SS_ESTABLISHED = 2'd2;
   localparam slot_state_type SS_ENDING      = 2'd3;

   // Report actions.
   localparam action_type ACT_NONE      = 2'd0;
   localparam action_type ACT_KEEPALIVE = 2'd1;
   localparam action_type ACT_TERMINATE = 2'd2;
   localparam action_type ACT_TIMEOUT   = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_IDLE_SECONDS    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CONTACT_TIMEOUT = 1'd1;

   localparam logic [SEC_W-1:0] CONTACT_TIMEOUT_RESET = 16'd60;

   // Operands of the shared counter unit.
   typedef struct packed {
      logic [CNT_W-1:0] value;
      logic [CNT_W:0]   bound;
      logic             narrow;
   } alu_req_type;

   // Results of the shared counter unit.
   typedef struct packed {
      logic [CNT_W-1:0] sum;
      logic             at_max;
      logic             ge;
      logic             gt;
   } alu_res_type;

endpackage

`default_nettype wire

### sv/skta_if.sv
`default_nettype none

interface skta_req_if
   import skta_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [SLOT_W-1:0] slot;
   logic [SEC_W-1:0]  keepalive_sec;
   logic              tx_busy;
   logic              rx_busy;

   modport source (output valid, op, slot, keepalive_sec, tx_busy, rx_busy, input ready);
   modport sink   (input valid, op, slot, keepalive_sec, tx_busy, rx_busy, output ready);
endinterface

interface skta_rsp_if
   import skta_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [SLOT_W-1:0] slot_out;
   logic [ACT_W-1:0]  action;
   logic              last;

   modport source (output valid, slot_out, action, last, input ready);
   modport sink   (input valid, slot_out, action, last, output ready);
endinterface

interface skta_csr_if
   import skta_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [SEC_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### sv/skta_alu.sv
`default_nettype none

module skta_alu
   import skta_pkg::*;
(
   input  alu_req_type req,
   output alu_res_type res
);

   logic at_max;

   // Saturating increment at 16 or 32 bits, then compare with the bound.
   always_comb begin
      if (req.narrow) begin
         at_max = (req.value[SEC_W-1:0] == {SEC_W{1'b1}});
      end else begin
         at_max = (req.value == {CNT_W{1'b1}});
      end
      res.at_max = at_max;
      res.sum    = at_max ? req.value : req.value + CNT_W'(1);
      res.ge     = ({1'b0, res.sum} >= req.bound);
      res.gt     = ({1'b0, res.sum} >  req.bound);
   end

endmodule

`default_nettype wire

### sv/session_keepalive_timeout_timers.sv
// Events pass through one event state before ready returns; they give no response.
// A tick scans every session in turn; each live one adds four steps on the shared
// saturating counter unit and a report state that waits on any response stall.
// No new request is accepted until the tick has finished.
// Reset is synchronous and active high: all sessions free, idle_seconds 0,
// contact_timeout 60, no response pending.
`default_nettype none

module session_keepalive_timeout_timers
   import skta_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   skta_req_if.sink    req_ch,
   skta_rsp_if.source  rsp_ch,
   skta_csr_if.sink    csr_ch
);

   // Sequencer codes.
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EVENT  = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_TX     = 3'd3;
   localparam logic [2:0] S_RX     = 3'd4;
   localparam logic [2:0] S_DATA   = 3'd5;
   localparam logic [2:0] S_NEG    = 3'd6;
   localparam logic [2:0] S_REPORT = 3'd7;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SESSIONS - 1);

   // Session table.
   slot_state_type   slot_state_ff [SESSIONS];
   logic [CNT_W-1:0] since_tx_ff   [SESSIONS];
   logic [CNT_W-1:0] since_rx_ff   [SESSIONS];
   logic [CNT_W-1:0] since_data_ff [SESSIONS];
   logic [SEC_W-1:0] neg_secs_ff   [SESSIONS];
   logic [SEC_W-1:0] ka_ivl_ff     [SESSIONS];
   logic             term_sent_ff  [SESSIONS];
   logic [1:0]       busy_ff       [SESSIONS];

   // Configuration registers.
   logic [SEC_W-1:0] idle_secs_ff, contact_to_ff;

   // Sequencer and latched request.
   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   op_type           op_ff;
   logic             ev_ok_ff;
   logic [SEC_W-1:0] ka_req_ff;
   logic [1:0]       busy_req_ff;

   // Per-session step results.
   logic ka_hit_ff, rx_to_ff, idle_hit_ff, neg_to_ff;

   // Response register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0] rsp_slot_ff;
   action_type        rsp_act_ff;
   logic              rsp_last_ff;

   alu_req_type alu_req;
   alu_res_type alu_res;

   slot_state_type   cur_state;
   logic [SEC_W-1:0] cur_ka;
   logic             req_acc, rsp_load, live_above, is_neg, term_hit, timed_out;
   action_type       act;

   assign req_acc       = req_ch.valid && req_ch.ready;
   assign req_ch.ready  = (state_ff == S_IDLE);
   assign csr_ch.ready  = 1'b1;
   assign cur_state     = slot_state_ff[idx_ff];
   assign cur_ka        = ka_ivl_ff[idx_ff];
   assign is_neg        = (cur_state == SS_NEGOTIATING);
   assign rsp_load      = (state_ff == S_REPORT) && (!rsp_valid_ff || rsp_ch.ready);
   assign rsp_valid_in  = rsp_load ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.slot_out = rsp_slot_ff;
   assign rsp_ch.action   = rsp_act_ff;
   assign rsp_ch.last     = rsp_last_ff;

   // Operand selection for the shared counter unit.
   always_comb begin
      alu_req = '0;
      unique case (state_ff)
         S_TX: begin
            alu_req.value = since_tx_ff[idx_ff];
            alu_req.bound = (CNT_W+1)'(cur_ka);
         end
         S_RX: begin
            alu_req.value = since_rx_ff[idx_ff];
            alu_req.bound = (CNT_W+1)'({cur_ka, 1'b0});
         end
         S_DATA: begin
            alu_req.value = since_data_ff[idx_ff];
            alu_req.bound = (CNT_W+1)'(idle_secs_ff);
         end
         S_NEG: begin
            alu_req.value  = CNT_W'(neg_secs_ff[idx_ff]);
            alu_req.bound  = (CNT_W+1)'(contact_to_ff);
            alu_req.narrow = 1'b1;
         end
         default: begin
            alu_req = '0;
         end
      endcase
   end

   skta_alu u_alu (
      .req (alu_req),
      .res (alu_res)
   );

   // Is any live session left above the current one?
   always_comb begin
      live_above = 1'b0;
      for (int i = 0; i < SESSIONS; i++) begin
         if ((slot_state_ff[i] != SS_FREE) && (i > int'(idx_ff))) begin
            live_above = 1'b1;
         end
      end
   end

   // Action of the current session, by priority.
   always_comb begin
      term_hit  = !is_neg && (cur_state == SS_ESTABLISHED) && (idle_secs_ff != '0) &&
                  !term_sent_ff[idx_ff] && (busy_ff[idx_ff] == 2'b00) && idle_hit_ff;
      timed_out = is_neg ? neg_to_ff : rx_to_ff;
      priority if (timed_out) begin
         act = ACT_TIMEOUT;
      end else if (term_hit) begin
         act = ACT_TERMINATE;
      end else if (!is_neg && ka_hit_ff) begin
         act = ACT_KEEPALIVE;
      end else begin
         act = ACT_NONE;
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_ch.op == OP_TICK) begin
                  state_in = S_SCAN;
                  idx_in   = '0;
               end else begin
                  state_in = S_EVENT;
                  idx_in   = IDX_W'(req_ch.slot);
               end
            end
         end
         S_EVENT: begin
            state_in = S_IDLE;
         end
         S_SCAN: begin
            if (cur_state != SS_FREE) begin
               state_in = S_TX;
            end else if (idx_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_TX: begin
            state_in = S_RX;
         end
         S_RX: begin
            state_in = S_DATA;
         end
         S_DATA: begin
            state_in = S_NEG;
         end
         S_NEG: begin
            state_in = S_REPORT;
         end
         S_REPORT: begin
            if (rsp_load) begin
               if (idx_ff == LAST_IDX) begin
                  state_in = S_IDLE;
               end else begin
                  state_in = S_SCAN;
                  idx_in   = idx_ff + IDX_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         idle_secs_ff  <= '0;
         contact_to_ff <= CONTACT_TIMEOUT_RESET;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            unique case (csr_ch.index)
               REG_IDLE_SECONDS:    idle_secs_ff  <= csr_ch.data;
               REG_CONTACT_TIMEOUT: contact_to_ff <= csr_ch.data;
               default: begin
               end
            endcase
         end
      end
   end

   // Session life states, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SESSIONS; i++) begin
            slot_state_ff[i] <= SS_FREE;
         end
      end else if (state_ff == S_EVENT && ev_ok_ff) begin
         unique case (op_ff)
            OP_OPEN:      slot_state_ff[idx_ff] <= SS_NEGOTIATING;
            OP_ESTABLISH: begin
               if (is_neg) begin
                  slot_state_ff[idx_ff] <= SS_ESTABLISHED;
               end
            end
            OP_CLOSE:     slot_state_ff[idx_ff] <= SS_FREE;
            default: begin
            end
         endcase
      end else if (rsp_load) begin
         if (timed_out) begin
            slot_state_ff[idx_ff] <= SS_FREE;
         end else if (term_hit) begin
            slot_state_ff[idx_ff] <= SS_ENDING;
         end
      end
   end

   // Latched request, step results, response and session counters.
   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff       <= req_ch.op;
         ev_ok_ff    <= (int'(req_ch.slot) < SESSIONS);
         ka_req_ff   <= req_ch.keepalive_sec;
         busy_req_ff <= {req_ch.rx_busy, req_ch.tx_busy};
      end
      if (rsp_load) begin
         rsp_slot_ff <= SLOT_W'(idx_ff);
         rsp_act_ff  <= act;
         rsp_last_ff <= !live_above;
         if (term_hit && !timed_out) begin
            term_sent_ff[idx_ff] <= 1'b1;
         end
      end
      unique case (state_ff)
         S_EVENT: begin
            if (ev_ok_ff) begin
               unique case (op_ff)
                  OP_OPEN: begin
                     since_tx_ff[idx_ff]   <= '0;
                     since_rx_ff[idx_ff]   <= '0;
                     since_data_ff[idx_ff] <= '0;
                     neg_secs_ff[idx_ff]   <= '0;
                     ka_ivl_ff[idx_ff]     <= '0;
                     term_sent_ff[idx_ff]  <= 1'b0;
                     busy_ff[idx_ff]       <= 2'b00;
                  end
                  OP_ESTABLISH: begin
                     if (is_neg) begin
                        ka_ivl_ff[idx_ff] <= ka_req_ff;
                     end
                  end
                  OP_SENT: begin
                     if (cur_state != SS_FREE) begin
                        since_tx_ff[idx_ff] <= '0;
                     end
                  end
                  OP_RECEIVED: begin
                     if (cur_state != SS_FREE) begin
                        since_rx_ff[idx_ff] <= '0;
                     end
                  end
                  OP_DATA: begin
                     if (cur_state != SS_FREE) begin
                        since_data_ff[idx_ff] <= '0;
                     end
                  end
                  OP_BUSY: begin
                     if (cur_state != SS_FREE) begin
                        busy_ff[idx_ff] <= busy_req_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_TX: begin
            since_tx_ff[idx_ff] <= alu_res.sum;
            ka_hit_ff           <= (cur_ka != '0) && alu_res.ge;
         end
         S_RX: begin
            since_rx_ff[idx_ff] <= alu_res.sum;
            rx_to_ff            <= (cur_ka != '0) && alu_res.gt;
         end
         S_DATA: begin
            since_data_ff[idx_ff] <= alu_res.sum;
            idle_hit_ff           <= alu_res.ge;
         end
         S_NEG: begin
            if (is_neg) begin
               neg_secs_ff[idx_ff] <= alu_res.sum[SEC_W-1:0];
            end
            neg_to_ff <= alu_res.at_max || alu_res.gt;
         end
         default: begin
         end
      endcase
   end

endmodule

`default_nettype wire

### verif/tb_top.sv
module tb_top
   import skta_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT   = 1_000_000;
   localparam int unsigned SETTLE_CYCLES = 120;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned SHOW_LIMIT    = 100;

   // Slot selection preferences for the random requests.
   localparam int PICK_FREE        = 0;
   localparam int PICK_NEGOTIATING = 1;
   localparam int PICK_LIVE        = 2;

   // One per-slot report of a tick.
   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      action_type        action;
      logic              last;
   } session_report_type;

   // Tracks the session table and the reports that each tick must produce.
   class keepalive_scoreboard;
      logic [SEC_W-1:0] idle_secs;
      logic [SEC_W-1:0] contact_limit;
      slot_state_type   life[SESSIONS];
      bit [CNT_W-1:0]   tx_age[SESSIONS];
      bit [CNT_W-1:0]   rx_age[SESSIONS];
      bit [CNT_W-1:0]   data_age[SESSIONS];
      bit [SEC_W-1:0]   nego_age[SESSIONS];
      bit [SEC_W-1:0]   ka_interval[SESSIONS];
      bit               term_mark[SESSIONS];
      bit [1:0]         busy[SESSIONS];
      session_report_type expected_reports[$];
      int unsigned      errors;
      int unsigned      shown;

      function new();
         idle_secs     = '0;
         contact_limit = CONTACT_TIMEOUT_RESET;
         errors        = 0;
         shown         = 0;
         for (int i = 0; i < SESSIONS; i++) begin
            life[i] = SS_FREE;
            clear_slot(i);
         end
      endfunction

      function void clear_slot(int s);
         tx_age[s]      = '0;
         rx_age[s]      = '0;
         data_age[s]    = '0;
         nego_age[s]    = '0;
         ka_interval[s] = '0;
         term_mark[s]   = 1'b0;
         busy[s]        = 2'b00;
      endfunction

      function void write_register(logic [CSR_IDX_W-1:0] index, logic [SEC_W-1:0] value);
         if (index == REG_IDLE_SECONDS) begin
            idle_secs = value;
         end else begin
            contact_limit = value;
         end
      endfunction

      function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      // Advances one live slot by a second and returns the action it reports.
      function action_type advance_session(int s);
         bit             timed_out;
         bit             send_term;
         bit             send_ka;
         bit             over;
         bit [CNT_W:0]   double_ka;
         timed_out   = 1'b0;
         send_term   = 1'b0;
         send_ka     = 1'b0;
         tx_age[s]   = bump(tx_age[s]);
         rx_age[s]   = bump(rx_age[s]);
         data_age[s] = bump(data_age[s]);
         if (life[s] == SS_NEGOTIATING) begin
            over = (nego_age[s] == '1);
            if (!over) begin
               nego_age[s] = nego_age[s] + 1'b1;
            end
            if (over || nego_age[s] > contact_limit) begin
               timed_out = 1'b1;
            end
         end else begin
            if (ka_interval[s] != 0) begin
               double_ka = (CNT_W+1)'({ka_interval[s], 1'b0});
               if (tx_age[s] >= ka_interval[s]) begin
                  send_ka = 1'b1;
               end
               if ({1'b0, rx_age[s]} > double_ka) begin
                  timed_out = 1'b1;
               end
            end
            if (idle_secs != 0 && life[s] == SS_ESTABLISHED && !term_mark[s] &&
                busy[s] == 2'b00 && data_age[s] >= idle_secs) begin
               term_mark[s] = 1'b1;
               life[s]      = SS_ENDING;
               send_term    = 1'b1;
            end
         end
         if (timed_out) begin
            life[s] = SS_FREE;
            return ACT_TIMEOUT;
         end
         if (send_term) begin
            return ACT_TERMINATE;
         end
         if (send_ka) begin
            return ACT_KEEPALIVE;
         end
         return ACT_NONE;
      endfunction

      // Applies an accepted request and queues the reports of a tick.
      function void note_request(op_type op, logic [SLOT_W-1:0] slot, logic [SEC_W-1:0] ka,
                                 logic txb, logic rxb);
         session_report_type rep;
         int                 first;
         first = expected_reports.size();
         case (op)
            OP_TICK: begin
               for (int i = 0; i < SESSIONS; i++) begin
                  if (life[i] != SS_FREE) begin
                     rep.slot   = i[SLOT_W-1:0];
                     rep.action = advance_session(i);
                     rep.last   = 1'b0;
                     expected_reports.push_back(rep);
                  end
               end
               if (expected_reports.size() > first) begin
                  expected_reports[expected_reports.size()-1].last = 1'b1;
               end
            end
            OP_OPEN: begin
               life[slot] = SS_NEGOTIATING;
               clear_slot(slot);
            end
            OP_ESTABLISH: begin
               if (life[slot] == SS_NEGOTIATING) begin
                  life[slot]        = SS_ESTABLISHED;
                  ka_interval[slot] = ka;
               end
            end
            OP_SENT: begin
               if (life[slot] != SS_FREE) tx_age[slot] = '0;
            end
            OP_RECEIVED: begin
               if (life[slot] != SS_FREE) rx_age[slot] = '0;
            end
            OP_DATA: begin
               if (life[slot] != SS_FREE) data_age[slot] = '0;
            end
            OP_BUSY: begin
               if (life[slot] != SS_FREE) busy[slot] = {rxb, txb};
            end
            default: begin
               life[slot] = SS_FREE;
            end
         endcase
      endfunction

      function void complain(string what, int unsigned want, int unsigned got);
         errors++;
         if (shown < SHOW_LIMIT) begin
            shown++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
         end
      endfunction

      // Compares a delivered report with the oldest one still owed.
      function void check_report(logic [SLOT_W-1:0] slot, action_type action, logic last);
         session_report_type want;
         if (expected_reports.size() == 0) begin
            errors++;
            if (shown < SHOW_LIMIT) begin
               shown++;
               $display("%0t: unexpected report: expected none, actual slot %0d action %0d last %0d",
                        $time, slot, action, last);
            end
            return;
         end
         want = expected_reports.pop_front();
         if (slot !== want.slot) complain("slot_out", want.slot, slot);
         if (action !== want.action) complain("action", want.action, action);
         if (last !== want.last) complain("last", want.last, last);
      endfunction

      function int pending();
         return expected_reports.size();
      endfunction

      function void flush_leftovers();
         while (expected_reports.size() > 0) begin
            complain("missing report for slot", expected_reports[0].slot, 0);
            void'(expected_reports.pop_front());
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   rsp_hold_request;

   skta_req_if req_ch();
   skta_rsp_if rsp_ch();
   skta_csr_if csr_ch();

   keepalive_scoreboard sb = new();

   session_keepalive_timeout_timers u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Run limit in case the block hangs.
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("TB_ERROR");
      $finish;
   end

   // Observes every handshake at the rising edge; reports before requests so that a
   // tick accepted on the edge of an earlier tick's last report is ordered correctly.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_report(rsp_ch.slot_out, rsp_ch.action, rsp_ch.last);
         end
         if (req_ch.valid && req_ch.ready) begin
            sb.note_request(req_ch.op, req_ch.slot, req_ch.keepalive_sec,
                            req_ch.tx_busy, req_ch.rx_busy);
         end
         if (csr_ch.valid && csr_ch.ready) begin
            sb.write_register(csr_ch.index, csr_ch.data);
         end
      end
   end

   // Report receiver: changes its stall pattern now and then, and holds off for a
   // long stretch when asked.
   initial begin : report_sink
      int unsigned pattern_left;
      int unsigned pattern;
      int unsigned stall_left;
      pattern_left = 0;
      pattern      = 0;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            rsp_hold_request = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern      = $urandom_range(3);
               pattern_left = $urandom_range(20, 120);
            end
            pattern_left--;
            case (pattern)
               0: rsp_ch.ready <= 1'b1;
               1: rsp_ch.ready <= $urandom_range(1);
               2: rsp_ch.ready <= ($urandom_range(3) == 0);
               default: begin
                  if (stall_left > 0) begin
                     rsp_ch.ready <= 1'b0;
                     stall_left--;
                  end else begin
                     rsp_ch.ready <= 1'b1;
                     if ($urandom_range(7) == 0) stall_left = $urandom_range(1, 25);
                  end
               end
            endcase
         end
      end
   end

   // Offers one request and returns at the edge where it is accepted.
   task automatic send_request(op_type op, logic [SLOT_W-1:0] slot, logic [SEC_W-1:0] ka,
                               logic txb, logic rxb);
      @(negedge clock);
      req_ch.valid         <= 1'b1;
      req_ch.op            <= op;
      req_ch.slot          <= slot;
      req_ch.keepalive_sec <= ka;
      req_ch.tx_busy       <= txb;
      req_ch.rx_busy       <= rxb;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic idle_sender(int unsigned cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] index, logic [SEC_W-1:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_reports();
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // Stops offering, collects every owed report and lets a worst-case tick finish.
   task automatic drain_and_settle();
      idle_sender(1);
      wait_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Picks a slot in the wanted life state most of the time, any slot otherwise.
   function automatic logic [SLOT_W-1:0] choose_slot(int wanted);
      int cands[$];
      for (int i = 0; i < SESSIONS; i++) begin
         if ((wanted == PICK_FREE && sb.life[i] == SS_FREE) ||
             (wanted == PICK_NEGOTIATING && sb.life[i] == SS_NEGOTIATING) ||
             (wanted == PICK_LIVE && sb.life[i] != SS_FREE)) begin
            cands.push_back(i);
         end
      end
      if (cands.size() == 0 || $urandom_range(6) == 0) begin
         return SLOT_W'($urandom_range(SESSIONS - 1));
      end
      return SLOT_W'(cands[$urandom_range(cands.size() - 1)]);
   endfunction

   // Random session traffic in bursts; optionally forces a long report hold-off
   // and a full pause of the sender.
   task automatic run_random(int unsigned count, bit hold_off, bit pause);
      op_type            op;
      logic [SLOT_W-1:0] slot;
      logic [SEC_W-1:0]  ka;
      logic              txb;
      logic              rxb;
      int unsigned       r;
      int unsigned       burst;
      burst = 0;
      for (int unsigned n = 0; n < count; n++) begin
         if (hold_off && n == count / 4) rsp_hold_request = 1'b1;
         if (pause && n == count / 2) begin
            idle_sender(1);
            wait_reports();
         end
         if (burst == 0) begin
            idle_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8));
            burst = $urandom_range(1, 16);
         end
         burst--;
         r = $urandom_range(99);
         if (r < 28) op = OP_TICK;
         else if (r < 38) op = OP_OPEN;
         else if (r < 50) op = OP_ESTABLISH;
         else if (r < 60) op = OP_SENT;
         else if (r < 72) op = OP_RECEIVED;
         else if (r < 82) op = OP_DATA;
         else if (r < 92) op = OP_BUSY;
         else op = OP_CLOSE;
         case (op)
            OP_OPEN:      slot = choose_slot(PICK_FREE);
            OP_ESTABLISH: slot = choose_slot(PICK_NEGOTIATING);
            default:      slot = choose_slot(PICK_LIVE);
         endcase
         r = $urandom_range(99);
         if (r < 15) ka = SEC_W'($urandom_range(16'hFFFF));
         else if (r < 30) ka = '0;
         else ka = SEC_W'($urandom_range(1, 6));
         if (op == OP_BUSY && $urandom_range(1) == 0) begin
            txb = 1'b0;
            rxb = 1'b0;
         end else begin
            txb = 1'($urandom_range(1));
            rxb = 1'($urandom_range(1));
         end
         send_request(op, slot, ka, txb, rxb);
      end
   endtask

   initial begin : stimulus
      logic [SEC_W-1:0] idle_cfg[6];
      logic [SEC_W-1:0] contact_cfg[6];
      reset                = 1'b1;
      rsp_hold_request     = 1'b0;
      req_ch.valid         = 1'b0;
      req_ch.op            = OP_TICK;
      req_ch.slot          = '0;
      req_ch.keepalive_sec = '0;
      req_ch.tx_busy       = 1'b0;
      req_ch.rx_busy       = 1'b0;
      csr_ch.valid         = 1'b0;
      csr_ch.index         = REG_IDLE_SECONDS;
      csr_ch.data          = '0;
      idle_cfg    = '{16'd4, 16'd0, 16'hFFFF, 16'd2, 16'd0, 16'd9};
      contact_cfg = '{16'd6, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd3};
      idle_cfg[4]    = SEC_W'($urandom_range(1, 12));
      contact_cfg[4] = SEC_W'($urandom_range(2, 20));
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part under the reset settings.
      send_request(OP_TICK, 4'd9, 16'hFFFF, 1'b1, 1'b1);    // empty table, no report
      send_request(OP_SENT, 4'd3, 16'd0, 1'b0, 1'b0);       // events on a free slot
      send_request(OP_BUSY, 4'd3, 16'd0, 1'b1, 1'b1);
      send_request(OP_CLOSE, 4'd3, 16'd0, 1'b0, 1'b0);
      send_request(OP_ESTABLISH, 4'd3, 16'd7, 1'b0, 1'b0);
      send_request(OP_OPEN, 4'd0, 16'd0, 1'b0, 1'b0);
      send_request(OP_OPEN, 4'd15, 16'd0, 1'b0, 1'b0);
      send_request(OP_TICK, 4'd0, 16'd0, 1'b0, 1'b0);
      send_request(OP_ESTABLISH, 4'd0, 16'd1, 1'b0, 1'b0);
      send_request(OP_ESTABLISH, 4'd0, 16'd5, 1'b0, 1'b0);  // already established
      send_request(OP_TICK, 4'd0, 16'd0, 1'b0, 1'b0);       // keepalive due
      send_request(OP_TICK, 4'd0, 16'd0, 1'b0, 1'b0);       // no reception, times out
      send_request(OP_OPEN, 4'd15, 16'd0, 1'b0, 1'b0);      // reopen a used slot
      send_request(OP_ESTABLISH, 4'd15, 16'hFFFF, 1'b0, 1'b0);
      send_request(OP_BUSY, 4'd15, 16'd0, 1'b1, 1'b0);
      send_request(OP_BUSY, 4'd15, 16'd0, 1'b0, 1'b1);
      send_request(OP_SENT, 4'd15, 16'd0, 1'b0, 1'b0);
      send_request(OP_RECEIVED, 4'd15, 16'd0, 1'b0, 1'b0);
      send_request(OP_DATA, 4'd15, 16'd0, 1'b0, 1'b0);
      send_request(OP_OPEN, 4'd7, 16'd0, 1'b0, 1'b0);
      send_request(OP_ESTABLISH, 4'd7, 16'd0, 1'b0, 1'b0);
      send_request(OP_TICK, 4'd0, 16'd0, 1'b0, 1'b0);
      send_request(OP_CLOSE, 4'd15, 16'd0, 1'b0, 1'b0);
      send_request(OP_TICK, 4'd0, 16'd0, 1'b0, 1'b0);
      send_request(OP_CLOSE, 4'd7, 16'd0, 1'b0, 1'b0);
      drain_and_settle();

      // Random phases, each under its own register settings.
      for (int p = 0; p < 6; p++) begin
         write_csr(REG_IDLE_SECONDS, idle_cfg[p]);
         write_csr(REG_CONTACT_TIMEOUT, contact_cfg[p]);
         run_random(78, p == 2, p == 3);
         drain_and_settle();
      end

      sb.flush_leftovers();
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
